/* hw/rtl/voice_pitch_volume_follower_unit_macros.svh */
// Assertion macros shared by the pitch and volume follower RTL.
// Included by the files that check their own logic; needs nothing else.
`ifndef VOICE_PITCH_VOLUME_FOLLOWER_UNIT_MACROS_SVH
`define VOICE_PITCH_VOLUME_FOLLOWER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Property holds at every edge outside reset.
`define VPVF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");
// Consequent holds in the cycle after the antecedent.
`define VPVF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define VPVF_ASSERT(lbl, clk, rstn, prop)
`define VPVF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hw/rtl/vpvf_pkg.sv */
// Shared types, widths, register indexes and small tables for the follower.
// No dependencies.
package vpvf_pkg;

  localparam int LOUD_W  = 16;
  localparam int HZ_W    = 15;
  localparam int PLAY_W  = 15;
  localparam int VOL_W   = 11;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;
  localparam int GAIN_W  = 8;
  localparam int NOTE_CFG_W = 13;

  localparam int LOG_STEPS = 16;

  // Valid pitch window in Q11.4, both ends excluded (70 Hz and 1100 Hz)
  localparam logic [HZ_W-1:0] HZ_LOW  = 15'd1120;
  localparam logic [HZ_W-1:0] HZ_HIGH = 15'd17600;

  // 12 * round((4 + log2 440) * 2^16) - 69 * 2^16, note value in Q7.16 is 12*L - this
  localparam logic [23:0] LOG_NOTE_OFFSET = 24'd5529684;
  localparam logic [23:0] NOTE_LO_Q16     = 24'd2949120;   // 45 << 16
  localparam logic [23:0] NOTE_HI_Q16     = 24'd5505024;   // 84 << 16

  localparam logic [VOL_W-1:0] VOL_CAP = 11'd1792;
  localparam logic [4:0]       VOL_MUL = 5'd26;

  localparam logic [IDX_W-1:0] REG_SNAP_EN        = 3'd0;
  localparam logic [IDX_W-1:0] REG_GATE_LEVEL     = 3'd1;
  localparam logic [IDX_W-1:0] REG_GLIDE_GAIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_STEP       = 3'd3;
  localparam logic [IDX_W-1:0] REG_ATTACK_GAIN    = 3'd4;
  localparam logic [IDX_W-1:0] REG_RELEASE_GAIN   = 3'd5;
  localparam logic [IDX_W-1:0] REG_JUMP_LIMIT     = 3'd6;
  localparam logic [IDX_W-1:0] REG_CONFIRM_WINDOW = 3'd7;

  typedef struct packed {
    logic                  snap_en;
    logic [LOUD_W-1:0]     gate_level;
    logic [GAIN_W-1:0]     glide_gain;
    logic [NOTE_CFG_W-1:0] max_step;
    logic [GAIN_W-1:0]     attack_gain;
    logic [GAIN_W-1:0]     release_gain;
    logic [NOTE_CFG_W-1:0] jump_limit;
    logic [NOTE_CFG_W-1:0] confirm_window;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic log_step;
    logic target;
    logic jump;
    logic glide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // Semitones down to the nearest pentatonic class at or below this class
  function automatic logic [1:0] penta_down(input logic [3:0] pc);
    logic [1:0] d;
    case (pc)
      4'd1, 4'd3, 4'd5, 4'd8, 4'd10: d = 2'd1;
      4'd6, 4'd11:                   d = 2'd2;
      default:                       d = 2'd0;
    endcase
    return d;
  endfunction

  // Semitones up to the nearest pentatonic class strictly above this class
  function automatic logic [1:0] penta_up(input logic [3:0] pc);
    logic [1:0] u;
    case (pc)
      4'd1, 4'd3, 4'd6, 4'd8, 4'd11: u = 2'd1;
      4'd4, 4'd9:                    u = 2'd3;
      default:                       u = 2'd2;
    endcase
    return u;
  endfunction

endpackage

/* hw/rtl/vpvf_channels_if.sv */
// Handshake channel interfaces of the follower: frame input, result output, config writes.
// Depends on vpvf_pkg.
interface vpvf_sample_if;
  import vpvf_pkg::*;
  logic              valid;
  logic              ready;
  logic [LOUD_W-1:0] mic_loudness;
  logic [HZ_W-1:0]   pitch_hz;
  modport source(output valid, mic_loudness, pitch_hz, input ready);
  modport sink(input valid, mic_loudness, pitch_hz, output ready);
endinterface

interface vpvf_result_if;
  import vpvf_pkg::*;
  logic              valid;
  logic              ready;
  logic [PLAY_W-1:0] played_note;
  logic [VOL_W-1:0]  note_volume;
  logic              voiced;
  modport source(output valid, played_note, note_volume, voiced, input ready);
  modport sink(input valid, played_note, note_volume, voiced, output ready);
endinterface

interface vpvf_cfg_if;
  import vpvf_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/voice_pitch_volume_follower_unit.sv */
// Top level of the voice pitch and volume follower.
// Depends on vpvf_pkg, the channel interfaces, vpvf_cfg_regs, vpvf_ctrl and vpvf_dp.
//
//   channel    | role   | payload
//   -----------+--------+------------------------------------------
//   sample_i   | sink   | mic_loudness[15:0], pitch_hz[14:0]
//   result_o   | source | played_note[14:0], note_volume[10:0], voiced
//   cfg_i      | sink   | index[2:0], data[15:0]
//
// Each frame runs from its transfer through the log2's 16 squaring iterations on the single
// 31x31 multiplier, then the note target, jump test and glide steps, to its result entering
// the output register. A new frame is taken in the cycle after the result is loaded, so
// the unit takes no new frame before it is through with the last one; the result register
// lets it start while the previous result still waits. A stalled result holds the unit in
// its last step. Reset needs no clearing pass; the config port is always ready.
module voice_pitch_volume_follower_unit #(
  parameter int NOTE_FRAC_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vpvf_sample_if.sink   sample_i,
  vpvf_result_if.source result_o,
  vpvf_cfg_if.sink      cfg_i
);
  import vpvf_pkg::*;

  cfg_t    regs;
  cmd_t    cmd;
  status_t status;

  vpvf_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  vpvf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vpvf_dp #(
    .NOTE_FRAC_BITS (NOTE_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .regs_i         (regs),
    .mic_loudness_i (sample_i.mic_loudness),
    .pitch_hz_i     (sample_i.pitch_hz),
    .out_ready_i    (result_o.ready),
    .status_o       (status),
    .out_valid_o    (result_o.valid),
    .played_note_o  (result_o.played_note),
    .note_volume_o  (result_o.note_volume),
    .voiced_o       (result_o.voiced)
  );

endmodule

/* hw/rtl/vpvf_cfg_regs.sv */
// Configuration register file of the follower, written through the config channel.
// Depends on vpvf_pkg and vpvf_cfg_if.
module vpvf_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  vpvf_cfg_if.sink      cfg_i,
  output vpvf_pkg::cfg_t regs_o
);
  import vpvf_pkg::*;

  cfg_t regs_d, regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SNAP_EN:        regs_d.snap_en        = cfg_i.data[0];
        REG_GATE_LEVEL:     regs_d.gate_level     = cfg_i.data[LOUD_W-1:0];
        REG_GLIDE_GAIN:     regs_d.glide_gain     = cfg_i.data[GAIN_W-1:0];
        REG_MAX_STEP:       regs_d.max_step       = cfg_i.data[NOTE_CFG_W-1:0];
        REG_ATTACK_GAIN:    regs_d.attack_gain    = cfg_i.data[GAIN_W-1:0];
        REG_RELEASE_GAIN:   regs_d.release_gain   = cfg_i.data[GAIN_W-1:0];
        REG_JUMP_LIMIT:     regs_d.jump_limit     = cfg_i.data[NOTE_CFG_W-1:0];
        REG_CONFIRM_WINDOW: regs_d.confirm_window = cfg_i.data[NOTE_CFG_W-1:0];
        default:            regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.snap_en        <= 1'b0;
      regs_q.gate_level     <= 16'd786;
      regs_q.glide_gain     <= 8'd77;
      regs_q.max_step       <= 13'd1536;
      regs_q.attack_gain    <= 8'd90;
      regs_q.release_gain   <= 8'd26;
      regs_q.jump_limit     <= 13'd1792;
      regs_q.confirm_window <= 13'd384;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

/* hw/rtl/vpvf_ctrl.sv */
// Sequencing state machine of the follower: frame load, log iterations, note, glide, result.
// Depends on vpvf_pkg and the assertion macro header.
`include "voice_pitch_volume_follower_unit_macros.svh"

module vpvf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vpvf_pkg::status_t status_i,
  output vpvf_pkg::cmd_t    cmd_o
);
  import vpvf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOG    = 6'b000010,
    ST_TARGET = 6'b000100,
    ST_JUMP   = 6'b001000,
    ST_GLIDE  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e     state_d, state_q;
  logic [3:0] cnt_d, cnt_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_LOG;
        end
      end
      ST_LOG: begin
        cmd_o.log_step = 1'b1;
        cnt_d          = cnt_q + 4'd1;
        if (cnt_q == 4'(LOG_STEPS - 1)) begin
          state_d = ST_TARGET;
        end
      end
      ST_TARGET: begin
        cmd_o.target = 1'b1;
        state_d      = ST_JUMP;
      end
      ST_JUMP: begin
        cmd_o.jump = 1'b1;
        state_d    = ST_GLIDE;
      end
      ST_GLIDE: begin
        cmd_o.glide = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `VPVF_ASSERT_NEXT(a_accept_starts_log, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_LOG)
  `VPVF_ASSERT(a_log_runs_full, clk_i, rst_ni, state_q == ST_TARGET |-> $past(state_q, LOG_STEPS) == ST_LOG && $past(state_q, LOG_STEPS + 1) == ST_IDLE)
  `VPVF_ASSERT_NEXT(a_emit_stall_holds, clk_i, rst_ni, state_q == ST_EMIT && !status_i.out_free, state_q == ST_EMIT)

endmodule

/* hw/rtl/vpvf_dp.sv */
// Datapath of the follower: log2 by squaring, note target and jump test, glide,
// volume smoothing, pentatonic snap and the result register. Uses vpvf_pkg and the macro header.
`include "voice_pitch_volume_follower_unit_macros.svh"

module vpvf_dp #(
  parameter int NOTE_FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vpvf_pkg::cmd_t              cmd_i,
  input  vpvf_pkg::cfg_t              regs_i,
  input  logic [vpvf_pkg::LOUD_W-1:0] mic_loudness_i,
  input  logic [vpvf_pkg::HZ_W-1:0]   pitch_hz_i,
  input  logic                        out_ready_i,
  output vpvf_pkg::status_t           status_o,
  output logic                        out_valid_o,
  output logic [vpvf_pkg::PLAY_W-1:0] played_note_o,
  output logic [vpvf_pkg::VOL_W-1:0]  note_volume_o,
  output logic                        voiced_o
);
  import vpvf_pkg::*;

  localparam int NW      = 7 + NOTE_FRAC_BITS;
  localparam int CW      = (NW > NOTE_CFG_W) ? NW : NOTE_CFG_W;
  localparam int RND_SH  = 16 - NOTE_FRAC_BITS;
  localparam int RND_ADD = 1 << (15 - NOTE_FRAC_BITS);
  localparam logic [NW-1:0] NOTE_MIN   = NW'(45 << NOTE_FRAC_BITS);
  localparam logic [NW-1:0] NOTE_MAX   = NW'(84 << NOTE_FRAC_BITS);
  localparam logic [NW-1:0] NOTE_RESET = NW'(60 << NOTE_FRAC_BITS);

  function automatic logic [3:0] msb_pos(input logic [HZ_W-1:0] v);
    logic [3:0] p;
    p = '0;
    for (int k = 0; k < HZ_W; k++) begin
      if (v[k]) p = 4'(k);
    end
    return p;
  endfunction

  // frame registers
  logic             voiced_q, hit_q;
  logic [VOL_W-1:0] tvol_q;
  logic [30:0]      y_q;
  logic [3:0]       n_q;
  logic [15:0]      frac_q;
  logic [NW-1:0]    target_q;

  // follower state
  logic [NW-1:0]    held_d, held_q, pend_d, pend_q, glided_d, glided_q;
  logic             pend_v_d, pend_v_q;
  logic [VOL_W-1:0] vol_d, vol_q;

  // result register
  logic              out_valid_q;
  logic [PLAY_W-1:0] note_out_q;
  logic [VOL_W-1:0]  vol_out_q;
  logic              voiced_out_q;

  // ---- frame load
  logic              voiced_in, hit_in;
  logic [3:0]        n_in;
  logic [30:0]       y_in;
  logic [20:0]       lvl_prod;
  logic [12:0]       tvol_raw;
  logic [VOL_W-1:0]  tvol_in;

  always_comb begin
    voiced_in = mic_loudness_i > regs_i.gate_level;
    hit_in    = voiced_in && (pitch_hz_i > HZ_LOW) && (pitch_hz_i < HZ_HIGH);
    n_in      = msb_pos(pitch_hz_i);
    y_in      = 31'(pitch_hz_i) << (5'd30 - 5'(n_in));
    lvl_prod  = 21'(mic_loudness_i) * 21'(VOL_MUL) + 21'd128;
    tvol_raw  = lvl_prod[20:8];
    if (!voiced_in) begin
      tvol_in = '0;
    end else if (tvol_raw > 13'(VOL_CAP)) begin
      tvol_in = VOL_CAP;
    end else begin
      tvol_in = tvol_raw[VOL_W-1:0];
    end
  end

  // ---- one squaring step of the log
  logic [61:0] sq;
  logic [31:0] sq_hi;
  logic [30:0] y_next;
  logic        log_bit;

  always_comb begin
    sq      = 62'(y_q) * 62'(y_q);
    sq_hi   = sq[61:30];
    log_bit = sq_hi[31];
    y_next  = log_bit ? sq_hi[31:1] : sq_hi[30:0];
  end

  // ---- log to note, clamp and round
  logic [23:0] r12, x_c, x_rnd;

  always_comb begin
    r12 = 24'({n_q, frac_q}) * 24'd12;
    if (r12 < NOTE_LO_Q16 + LOG_NOTE_OFFSET) begin
      x_c = NOTE_LO_Q16;
    end else if (r12 > NOTE_HI_Q16 + LOG_NOTE_OFFSET) begin
      x_c = NOTE_HI_Q16;
    end else begin
      x_c = r12 - LOG_NOTE_OFFSET;
    end
    x_rnd = (x_c + 24'(RND_ADD)) >> RND_SH;
  end

  // ---- jump test
  logic [NW-1:0] d_held, d_pend;
  logic          near_held, near_pend;

  always_comb begin
    d_held    = (target_q > held_q) ? target_q - held_q : held_q - target_q;
    d_pend    = (target_q > pend_q) ? target_q - pend_q : pend_q - target_q;
    near_held = CW'(d_held) <= CW'(regs_i.jump_limit);
    near_pend = pend_v_q && (CW'(d_pend) <= CW'(regs_i.confirm_window));
    held_d    = held_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    if (cmd_i.jump && hit_q) begin
      if (near_held || near_pend) begin
        held_d   = target_q;
        pend_v_d = 1'b0;
      end else begin
        pend_d   = target_q;
        pend_v_d = 1'b1;
      end
    end
  end

  // ---- glide and volume steps, rounded half away from zero
  logic             g_neg;
  logic [NW-1:0]    g_mag, g_step, g_step_c;
  logic [NW+7:0]    g_prod;
  logic             v_up;
  logic [VOL_W-1:0] v_mag, v_step;
  logic [18:0]      v_prod;

  always_comb begin
    g_neg    = held_q < glided_q;
    g_mag    = g_neg ? glided_q - held_q : held_q - glided_q;
    g_prod   = (NW+8)'(g_mag) * (NW+8)'(regs_i.glide_gain) + (NW+8)'(128);
    g_step   = g_prod[NW+7:8];
    g_step_c = (CW'(g_step) > CW'(regs_i.max_step)) ? NW'(regs_i.max_step) : g_step;
    glided_d = glided_q;
    v_up     = tvol_q > vol_q;
    v_mag    = v_up ? tvol_q - vol_q : vol_q - tvol_q;
    v_prod   = 19'(v_mag) * 19'(v_up ? regs_i.attack_gain : regs_i.release_gain) + 19'd128;
    v_step   = v_prod[18:8];
    vol_d    = vol_q;
    if (cmd_i.glide) begin
      glided_d = g_neg ? glided_q - g_step_c : glided_q + g_step_c;
      vol_d    = v_up ? vol_q + v_step : vol_q - v_step;
    end
  end

  // ---- pentatonic snap of the glided note
  logic [6:0]       semi, pc7, lo_semi;
  logic [14:0]      q_prod;
  logic [3:0]       octave, pc;
  logic [7:0]       hi_semi;
  logic [NW-1:0]    lo_note, d_lo;
  logic [NW:0]      hi_note, d_hi, snap, play_full;
  logic [NW+15:0]   play_ext;

  always_comb begin
    semi      = glided_q[NW-1:NOTE_FRAC_BITS];
    q_prod    = 15'(semi) * 15'd171;    // floor(semi / 12) for semi below 128
    octave    = q_prod[14:11];
    pc7       = semi - 7'(octave) * 7'd12;
    pc        = pc7[3:0];
    lo_semi   = semi - 7'(penta_down(pc));
    hi_semi   = 8'(semi) + 8'(penta_up(pc));
    lo_note   = {lo_semi, {NOTE_FRAC_BITS{1'b0}}};
    hi_note   = {hi_semi, {NOTE_FRAC_BITS{1'b0}}};
    d_lo      = glided_q - lo_note;
    d_hi      = hi_note - (NW+1)'(glided_q);
    // lower note wins a tie
    snap      = ((NW+1)'(d_lo) <= d_hi) ? (NW+1)'(lo_note) : hi_note;
    play_full = regs_i.snap_en ? snap : (NW+1)'(glided_q);
    play_ext  = {15'b0, play_full};
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign played_note_o     = note_out_q;
  assign note_volume_o     = vol_out_q;
  assign voiced_o          = voiced_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= NOTE_RESET;
      glided_q    <= NOTE_RESET;
      pend_q      <= '0;
      pend_v_q    <= 1'b0;
      vol_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_q   <= held_d;
      glided_q <= glided_d;
      pend_q   <= pend_d;
      pend_v_q <= pend_v_d;
      vol_q    <= vol_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      voiced_q <= voiced_in;
      hit_q    <= hit_in;
      tvol_q   <= tvol_in;
      n_q      <= n_in;
      y_q      <= y_in;
      frac_q   <= '0;
    end
    if (cmd_i.log_step) begin
      y_q    <= y_next;
      frac_q <= {frac_q[14:0], log_bit};
    end
    if (cmd_i.target) begin
      target_q <= x_rnd[NW-1:0];
    end
    if (cmd_i.emit) begin
      note_out_q   <= play_ext[PLAY_W-1:0];
      vol_out_q    <= vol_q;
      voiced_out_q <= voiced_q;
    end
  end

  `VPVF_ASSERT(a_held_in_range, clk_i, rst_ni, held_q >= NOTE_MIN && held_q <= NOTE_MAX)
  `VPVF_ASSERT(a_glided_in_range, clk_i, rst_ni, glided_q >= NOTE_MIN && glided_q <= NOTE_MAX)
  `VPVF_ASSERT(a_volume_capped, clk_i, rst_ni, vol_q <= VOL_CAP)
  `VPVF_ASSERT_NEXT(a_emit_sets_valid, clk_i, rst_ni, cmd_i.emit, out_valid_o)

endmodule

/* verif/vpvf_checker.sv */
// Checker for the voice pitch and volume follower: mirrors the register file, predicts
// every frame and compares each result transfer field by field. Depends on vpvf_pkg and
// the channel interfaces vpvf_sample_if, vpvf_result_if and vpvf_cfg_if.
module vpvf_checker #(
  parameter int NOTE_FRAC = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vpvf_sample_if      sample_mon,
  vpvf_result_if      result_mon,
  vpvf_cfg_if         cfg_mon,
  output int unsigned mismatch_count,
  output int unsigned results_checked
);
  import vpvf_pkg::*;

  typedef struct packed {
    logic [PLAY_W-1:0] played_note;
    logic [VOL_W-1:0]  note_volume;
    logic              voiced;
  } frame_out_t;

  // (4 + log2 440) in Q16; the 4 accounts for the Hz fraction bits
  localparam longint LOG2_440_Q16 = 837639;
  localparam longint NOTE_69_Q16  = 69 * 65536;
  localparam longint NOTE_MIN_Q16 = 45 * 65536;
  localparam longint NOTE_MAX_Q16 = 84 * 65536;
  localparam longint NOTE_START   = longint'(60) << NOTE_FRAC;
  localparam longint VOLUME_CAP   = 1792;

  cfg_t       regs;
  longint     held_note, jump_note, glided_note, volume;
  bit         jump_pending;
  frame_out_t expected_q[$];

  function automatic longint note_gap(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // log2 of the Q11.4 word with 16 fraction bits, by repeated squaring
  function automatic longint freq_log2(longint unsigned v);
    int              msb;
    longint unsigned y;
    longint          acc;
    msb = 0;
    while (msb < 62 && (v >> (msb + 1)) != 0) msb++;
    y   = v << (30 - msb);
    acc = longint'(msb) * 65536;
    for (int bitpos = 15; bitpos >= 0; bitpos--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y   = y >> 1;
        acc = acc + (longint'(1) << bitpos);
      end
    end
    return acc;
  endfunction

  // gap * gain / 256, rounded half away from zero
  function automatic longint gain_step(longint gap, longint unsigned gain);
    longint unsigned mag;
    longint          s;
    mag = (gap < 0) ? -gap : gap;
    s   = longint'((mag * gain + 64'd128) >> 8);
    return (gap < 0) ? -s : s;
  endfunction

  // Ascending scan with a strict compare keeps the lower note on a tie
  function automatic longint nearest_pentatonic(longint note);
    longint best, best_d, cand, d;
    int     pc;
    best   = 0;
    best_d = 64'sh7FFF_FFFF_FFFF_FFFF;
    for (int semi = 0; semi < 108; semi++) begin
      pc = semi % 12;
      if (pc inside {0, 2, 4, 7, 9}) begin
        cand = longint'(semi) << NOTE_FRAC;
        d    = note_gap(note, cand);
        if (d < best_d) begin
          best_d = d;
          best   = cand;
        end
      end
    end
    return best;
  endfunction

  function automatic frame_out_t follow_frame(logic [LOUD_W-1:0] loud, logic [HZ_W-1:0] hz);
    frame_out_t      r;
    logic            is_voiced;
    longint          x, target, step, ms, tvol, played;
    longint unsigned g;
    is_voiced = loud > regs.gate_level;
    if (is_voiced && hz > HZ_LOW && hz < HZ_HIGH) begin
      x = NOTE_69_Q16 + 12 * (freq_log2(hz) - LOG2_440_Q16);
      if (x < NOTE_MIN_Q16) x = NOTE_MIN_Q16;
      if (x > NOTE_MAX_Q16) x = NOTE_MAX_Q16;
      target = (x + (longint'(1) << (15 - NOTE_FRAC))) >>> (16 - NOTE_FRAC);
      if (note_gap(target, held_note) <= longint'(regs.jump_limit)) begin
        held_note    = target;
        jump_pending = 1'b0;
      end else if (jump_pending &&
                   note_gap(target, jump_note) <= longint'(regs.confirm_window)) begin
        held_note    = target;
        jump_pending = 1'b0;
      end else begin
        jump_note    = target;
        jump_pending = 1'b1;
      end
    end

    ms   = longint'(regs.max_step);
    step = gain_step(held_note - glided_note, regs.glide_gain);
    if (step > ms) step = ms;
    if (step < -ms) step = -ms;
    glided_note = glided_note + step;
    played = regs.snap_en ? nearest_pentatonic(glided_note) : glided_note;

    tvol = 0;
    if (is_voiced) tvol = longint'((64'(loud) * 64'd26 + 64'd128) >> 8);
    if (tvol > VOLUME_CAP) tvol = VOLUME_CAP;
    g = (tvol > volume) ? regs.attack_gain : regs.release_gain;
    volume = volume + gain_step(tvol - volume, g);

    r.played_note = PLAY_W'(played);
    r.note_volume = VOL_W'(volume);
    r.voiced      = is_voiced;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_out_t want;
    int         bad;
    bad = 0;
    if (!rst_ni) begin
      regs = '{snap_en: 1'b0, gate_level: 16'd786, glide_gain: 8'd77,
               max_step: 13'd1536, attack_gain: 8'd90, release_gain: 8'd26,
               jump_limit: 13'd1792, confirm_window: 13'd384};
      held_note    = NOTE_START;
      glided_note  = NOTE_START;
      jump_note    = 0;
      jump_pending = 1'b0;
      volume       = 0;
      expected_q.delete();
      mismatch_count  <= 0;
      results_checked <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_SNAP_EN:        regs.snap_en        = cfg_mon.data[0];
          REG_GATE_LEVEL:     regs.gate_level     = cfg_mon.data[LOUD_W-1:0];
          REG_GLIDE_GAIN:     regs.glide_gain     = cfg_mon.data[GAIN_W-1:0];
          REG_MAX_STEP:       regs.max_step       = cfg_mon.data[NOTE_CFG_W-1:0];
          REG_ATTACK_GAIN:    regs.attack_gain    = cfg_mon.data[GAIN_W-1:0];
          REG_RELEASE_GAIN:   regs.release_gain   = cfg_mon.data[GAIN_W-1:0];
          REG_JUMP_LIMIT:     regs.jump_limit     = cfg_mon.data[NOTE_CFG_W-1:0];
          REG_CONFIRM_WINDOW: regs.confirm_window = cfg_mon.data[NOTE_CFG_W-1:0];
          default: ;
        endcase
      end

      // check results before queuing this edge's frame
      if (result_mon.valid && result_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no frame outstanding");
          bad++;
        end else begin
          want = expected_q.pop_front();
          if (result_mon.played_note !== want.played_note) begin
            $error("played_note mismatch: expected %0d, actual %0d",
                   want.played_note, result_mon.played_note);
            bad++;
          end
          if (result_mon.note_volume !== want.note_volume) begin
            $error("note_volume mismatch: expected %0d, actual %0d",
                   want.note_volume, result_mon.note_volume);
            bad++;
          end
          if (result_mon.voiced !== want.voiced) begin
            $error("voiced mismatch: expected %0d, actual %0d",
                   want.voiced, result_mon.voiced);
            bad++;
          end
        end
        results_checked <= results_checked + 1;
      end

      if (sample_mon.valid && sample_mon.ready)
        expected_q.push_back(follow_frame(sample_mon.mic_loudness, sample_mon.pitch_hz));

      mismatch_count <= mismatch_count + bad;
    end
  end

endmodule

/* verif/testbench.sv */
// Top of the follower testbench: clock, reset, frame and register stimulus, result stalls
// and the verdict. Depends on vpvf_pkg, the channel interfaces, the follower unit and
// vpvf_checker.
module testbench;
  import vpvf_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  bit          steady;
  int unsigned frames_sent;
  int unsigned mismatch_count;
  int unsigned results_checked;
  logic [LOUD_W-1:0] cur_gate;

  vpvf_sample_if sample_if ();
  vpvf_result_if result_if ();
  vpvf_cfg_if    cfg_if ();

  voice_pitch_volume_follower_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  vpvf_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_mon      (sample_if),
    .result_mon      (result_if),
    .cfg_mon         (cfg_if),
    .mismatch_count  (mismatch_count),
    .results_checked (results_checked)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [HZ_W-1:0] in_range_hz();
    return HZ_W'($urandom_range(int'(HZ_HIGH) - 1, int'(HZ_LOW) + 1));
  endfunction

  function automatic logic [LOUD_W-1:0] loud_voiced();
    int top;
    if (cur_gate == '1) return LOUD_W'($urandom_range(0, 65535));
    top = 65535;
    if ($urandom_range(0, 1) && int'(cur_gate) + 20000 < 65535) top = int'(cur_gate) + 20000;
    return LOUD_W'($urandom_range(top, int'(cur_gate) + 1));
  endfunction

  task automatic send_frame(input logic [LOUD_W-1:0] loud, input logic [HZ_W-1:0] hz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid        <= 1'b1;
    sample_if.mic_loudness <= loud;
    sample_if.pitch_hz     <= hz;
    do @(posedge clk_i); while (!sample_if.ready);
    frames_sent++;
  endtask

  // Drop valid and hold until every frame has its result
  task automatic drain();
    sample_if.valid <= 1'b0;
    while (results_checked != frames_sent) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic apply_setting(input logic [DATA_W-1:0] mode, gate, glide, mstep,
                               input logic [DATA_W-1:0] att, rel, jump, window);
    cfg_if.valid <= 1'b1;
    put_reg(REG_SNAP_EN, mode);
    put_reg(REG_GATE_LEVEL, gate);
    put_reg(REG_GLIDE_GAIN, glide);
    put_reg(REG_MAX_STEP, mstep);
    put_reg(REG_ATTACK_GAIN, att);
    put_reg(REG_RELEASE_GAIN, rel);
    put_reg(REG_JUMP_LIMIT, jump);
    put_reg(REG_CONFIRM_WINDOW, window);
    cfg_if.valid <= 1'b0;
    cur_gate = gate;
  endtask

  // Mostly voiced frames and jump/confirm pairs, with some noise and silence
  task automatic play_mix(input int count);
    int made, kind, h;
    logic [HZ_W-1:0] hz;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        send_frame(LOUD_W'($urandom_range(0, 65535)), HZ_W'($urandom_range(0, 32767)));
        made++;
      end else if (kind < 22) begin
        send_frame(LOUD_W'($urandom_range(int'(cur_gate), 0)), in_range_hz());
        made++;
      end else if (kind < 55) begin
        send_frame(loud_voiced(), in_range_hz());
        made++;
      end else begin
        hz = in_range_hz();
        send_frame(loud_voiced(), hz);
        h = int'(hz) + $urandom_range(0, 60) - 30;
        if (h <= int'(HZ_LOW)) h = int'(HZ_LOW) + 1;
        if (h >= int'(HZ_HIGH)) h = int'(HZ_HIGH) - 1;
        send_frame(loud_voiced(), HZ_W'(h));
        made += 2;
        if (kind >= 90) begin
          send_frame(loud_voiced(), in_range_hz());
          made++;
        end
      end
    end
  endtask

  task automatic sweep_hz(input int lo, input int hi);
    for (int h = lo; h <= hi; h++) send_frame(loud_voiced(), HZ_W'(h));
  endtask

  // Result side: random stalls between runs of ready
  initial begin
    result_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      int stall;
      stall = pick_gap();
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    #(8 * 1_500_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni                 = 1'b0;
    steady                 = 1'b0;
    frames_sent            = 0;
    cur_gate               = 16'd786;
    sample_if.valid        = 1'b0;
    sample_if.mic_loudness = '0;
    sample_if.pitch_hz     = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = REG_SNAP_EN;
    cfg_if.data            = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames on the reset register values
    send_frame(16'd0, 15'd0);
    send_frame(16'd786, 15'd7040);       // loudness equal to gate is silence
    send_frame(16'd787, 15'd7040);       // A4 is too far from the start note: pending
    send_frame(16'hFFFF, 15'd7040);      // confirm; volume target capped
    send_frame(16'hFFFF, 15'd1120);      // low pitch edge is excluded
    send_frame(16'hFFFF, 15'd1121);      // clamps to the lowest note
    send_frame(16'hFFFF, 15'd17600);     // high pitch edge is excluded
    send_frame(16'hFFFF, 15'd17599);     // clamps to the highest note, replaces pending
    send_frame(16'hFFFF, 15'd17599);
    send_frame(16'd40000, 15'h7FFF);
    send_frame(16'd40000, 15'd7040);
    send_frame(16'd40000, 15'd3520);     // different jump replaces the pending one
    send_frame(16'd40000, 15'd3520);
    send_frame(16'd17650, 15'd3729);     // small change taken at once
    send_frame(16'd17700, 15'd3729);
    send_frame(16'd0, 15'd3729);         // release
    repeat (4) send_frame(16'd20000, 15'd3729);
    send_frame(16'd800, 15'd5461);
    send_frame(16'h5555, 15'h2AAA);
    send_frame(16'hAAAA, 15'h5555);
    play_mix(100);
    drain();

    // Extremes: nothing passes the gate, then any nonzero loudness does; then every register zero
    apply_setting(16'd1, 16'hFFFF, 16'd255, 16'd8191, 16'd255, 16'd255, 16'd8191, 16'd8191);
    play_mix(25);
    drain();
    apply_setting(16'd1, 16'd0, 16'd255, 16'd8191, 16'd255, 16'd255, 16'd8191, 16'd8191);
    play_mix(60);
    drain();
    apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    play_mix(40);
    drain();

    // Fast glide in scale mode; sweep across snap midpoints
    apply_setting(16'd1, 16'd0, 16'd255, 16'd8191, 16'd255, 16'd0, 16'd8191, 16'd8191);
    steady = 1'b1;
    sweep_hz(5736, 5768);
    steady = 1'b0;
    sweep_hz(4425, 4445);
    drain();

    // Tight jump limit and window
    apply_setting(16'd0, 16'd1000, 16'd128, 16'd300, 16'd200, 16'd10, 16'd256, 16'd64);
    steady = 1'b1;
    play_mix(60);
    steady = 1'b0;
    play_mix(60);
    drain();

    repeat (3) begin
      apply_setting(DATA_W'($urandom_range(0, 65535)), DATA_W'($urandom_range(0, 65535)),
                    DATA_W'($urandom_range(0, 65535)), DATA_W'($urandom_range(0, 65535)),
                    DATA_W'($urandom_range(0, 65535)), DATA_W'($urandom_range(0, 65535)),
                    DATA_W'($urandom_range(0, 65535)), DATA_W'($urandom_range(0, 65535)));
      play_mix(70);
      drain();
    end

    apply_setting(16'd0, 16'd786, 16'd77, 16'd1536, 16'd90, 16'd26, 16'd1792, 16'd384);
    play_mix(60);
    drain();

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && results_checked == frames_sent) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
